[sv/sorted_multiset_table_top_defines.svh]
// Assertion macros used by the checker file smt_checker.sv.
`ifndef SORTED_MULTISET_TABLE_TOP_DEFINES_SVH
`define SORTED_MULTISET_TABLE_TOP_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define SMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define SMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants for the sorted multiset table.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

    localparam int Capacity   = 128;
    localparam int ValueWidth = 32;
    localparam int SlotWidth  = $clog2(Capacity + 1);
    localparam int IdxWidth   = $clog2(Capacity);

    typedef logic [SlotWidth-1:0]  t_slot;
    typedef logic [ValueWidth-1:0] t_value;

    localparam t_slot NilLink = t_slot'(Capacity);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_COUNT  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [7:0] occurrences;
        logic [7:0] entries;
        logic       is_empty;
        logic       rejected;
    } t_rsp;

    // One link memory write: enable, address and data.
    typedef struct packed {
        logic                we;
        logic [IdxWidth-1:0] waddr;
        t_slot               wdata;
    } t_link_wr;

    function automatic logic live(input t_slot s);
        return s < NilLink;
    endfunction

endpackage

`default_nettype wire

[sv/smt_if.sv]
// ----------------------------------------------------------------------------
// smt_req_if / smt_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface smt_req_if;
    import smt_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] value;
    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface smt_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] occurrences;
    logic [7:0] entries;
    logic       is_empty;
    logic       rejected;
    modport source (output valid, output found, output occurrences, output entries,
                    output is_empty, output rejected, input ready);
    modport sink   (input valid, input found, input occurrences, input entries,
                    input is_empty, input rejected, output ready);
endinterface

`default_nettype wire

[sv/smt_link_ram.sv]
// ----------------------------------------------------------------------------
// smt_link_ram
// Link memory: one write port and one registered read port. A reset sweep
// loads the free chain (slot i points to i+1) for next links.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_link_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_init,
    input  wire logic [smt_pkg::IdxWidth-1:0] i_raddr,
    input  wire smt_pkg::t_link_wr          i_wr,
    output      smt_pkg::t_slot             o_rdata
);
    import smt_pkg::*;

    t_slot r_mem [Capacity];
    logic [IdxWidth-1:0] r_init_idx;

    // Write on init sweep or on request; read registered.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_mem[r_init_idx] <= t_slot'({1'b0, r_init_idx}) + t_slot'(1);
        end else if (i_wr.we) begin
            r_mem[i_wr.waddr] <= i_wr.wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

    // Advance the sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_idx <= '0;
        end else if (i_init) begin
            r_init_idx <= r_init_idx + 1'b1;
        end
    end
endmodule

`default_nettype wire

[sv/smt_value_ram.sv]
// ----------------------------------------------------------------------------
// smt_value_ram
// Element value memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_value_ram (
    input  wire logic                         i_clk,
    input  wire logic [smt_pkg::IdxWidth-1:0] i_raddr,
    input  wire logic                         i_we,
    input  wire logic [smt_pkg::IdxWidth-1:0] i_waddr,
    input  wire smt_pkg::t_value              i_wdata,
    output      smt_pkg::t_value              o_rdata
);
    import smt_pkg::*;

    t_value r_mem [Capacity];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

[sv/smt_ctrl.sv]
// ----------------------------------------------------------------------------
// smt_ctrl
// Sequencer: walks the list slot by slot, a read state then a compare state
// per slot, and relinks on insert and remove, then registers one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    smt_req_if.sink                           req,
    smt_rsp_if.source                         rsp,
    output      logic                         o_init,
    output      logic [smt_pkg::IdxWidth-1:0] o_val_raddr,
    output      logic                         o_val_we,
    output      logic [smt_pkg::IdxWidth-1:0] o_val_waddr,
    output      smt_pkg::t_value              o_val_wdata,
    input  wire smt_pkg::t_value              i_val_rdata,
    output      logic [smt_pkg::IdxWidth-1:0] o_nxt_raddr,
    output      smt_pkg::t_link_wr            o_nxt_wr,
    input  wire smt_pkg::t_slot               i_nxt_rdata,
    output      logic [smt_pkg::IdxWidth-1:0] o_prv_raddr,
    output      smt_pkg::t_link_wr            o_prv_wr,
    input  wire smt_pkg::t_slot               i_prv_rdata
);
    import smt_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FREE_RD, S_FREE_WAIT, S_WALK_RD, S_WALK_CMP,
        S_LINK, S_RM_RD, S_RM_WAIT, S_RM_FIX, S_DONE
    } t_state;

    localparam int CntWidth = $clog2(Capacity + 1);

    t_state              r_state;
    logic [1:0]          r_act;
    t_value              r_val;
    t_slot               r_cur, r_new, r_head, r_tail, r_free, r_p, r_n;
    logic [CntWidth-1:0] r_count, r_occ, r_steps;
    logic [IdxWidth-1:0] r_init_idx;
    logic                r_hit, r_rej;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic ge_cur, eq_cur;
    t_value key_cur, key_req;
    logic rsp_load;

    // Compare stored and requested value as signed.
    assign key_cur = i_val_rdata ^ {1'b1, {(ValueWidth-1){1'b0}}};
    assign key_req = r_val ^ {1'b1, {(ValueWidth-1){1'b0}}};
    assign eq_cur  = key_cur == key_req;
    assign ge_cur  = key_cur > key_req;

    // Load the result register once the previous beat has left it.
    assign rsp_load = (r_state == S_DONE) && (!r_rsp_valid || rsp.ready);

    assign o_init      = r_state == S_INIT;
    assign req.ready   = r_state == S_IDLE;
    assign rsp.valid   = r_rsp_valid;
    assign rsp.found       = r_rsp.found;
    assign rsp.occurrences = r_rsp.occurrences;
    assign rsp.entries     = r_rsp.entries;
    assign rsp.is_empty    = r_rsp.is_empty;
    assign rsp.rejected    = r_rsp.rejected;

    // Memory reads follow the walk pointer; next-link reads r_free in idle.
    always_comb begin
        o_val_raddr = r_cur[IdxWidth-1:0];
        o_nxt_raddr = r_cur[IdxWidth-1:0];
        o_prv_raddr = r_cur[IdxWidth-1:0];
        if (r_state == S_IDLE || r_state == S_FREE_RD) begin
            o_nxt_raddr = r_free[IdxWidth-1:0];
        end
    end

    // Memory writes: the new value on insert, and the links for relinking.
    always_comb begin
        o_val_we    = 1'b0;
        o_val_waddr = r_free[IdxWidth-1:0];
        o_val_wdata = r_val;
        o_nxt_wr    = '0;
        o_prv_wr    = '0;
        case (r_state)
            S_FREE_WAIT: begin
                o_val_we = 1'b1;
            end
            S_LINK: begin
                // New slot points forward to the stop slot.
                o_nxt_wr = '{we: 1'b1, waddr: r_new[IdxWidth-1:0], wdata: r_cur};
                o_prv_wr = '{we: 1'b1, waddr: r_new[IdxWidth-1:0], wdata: r_p};
            end
            S_RM_FIX: begin
                o_nxt_wr = '{we: 1'b1, waddr: r_cur[IdxWidth-1:0], wdata: r_free};
                o_prv_wr = '{we: 1'b1, waddr: r_cur[IdxWidth-1:0], wdata: NilLink};
            end
            S_DONE: begin
                if (r_act == ACT_INSERT && !r_rej) begin
                    if (live(r_p)) begin
                        o_nxt_wr = '{we: 1'b1, waddr: r_p[IdxWidth-1:0], wdata: r_new};
                    end
                    if (live(r_cur)) begin
                        o_prv_wr = '{we: 1'b1, waddr: r_cur[IdxWidth-1:0], wdata: r_new};
                    end
                end else if (r_act == ACT_REMOVE && r_hit) begin
                    if (live(r_p)) begin
                        o_nxt_wr = '{we: 1'b1, waddr: r_p[IdxWidth-1:0], wdata: r_n};
                    end
                    if (live(r_n)) begin
                        o_prv_wr = '{we: 1'b1, waddr: r_n[IdxWidth-1:0], wdata: r_p};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Hold state, pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= NilLink;
            r_tail      <= NilLink;
            r_free      <= '0;
            r_count     <= '0;
            r_init_idx  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_idx <= r_init_idx + 1'b1;
                    if (r_init_idx == IdxWidth'(Capacity - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req.valid) begin
                        r_act   <= req.action;
                        r_val   <= req.value;
                        r_cur   <= r_head;
                        r_p     <= r_tail;
                        r_occ   <= '0;
                        r_steps <= '0;
                        r_hit   <= 1'b0;
                        r_rej   <= 1'b0;
                        if (req.action == ACT_INSERT) begin
                            if (live(r_free)) begin
                                r_state <= S_FREE_WAIT;
                            end else begin
                                r_rej   <= 1'b1;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_WAIT;
                end
                S_FREE_WAIT: begin
                    // Pop free slot; next link already read.
                    r_new   <= r_free;
                    r_free  <= i_nxt_rdata;
                    r_state <= S_WALK_RD;
                end
                S_WALK_RD: begin
                    if (!live(r_cur) || r_steps == CntWidth'(Capacity)) begin
                        r_cur   <= NilLink;
                        r_p     <= r_tail;
                        r_state <= (r_act == ACT_INSERT) ? S_LINK : S_DONE;
                    end else begin
                        r_state <= S_WALK_CMP;
                    end
                end
                S_WALK_CMP: begin
                    r_steps <= r_steps + 1'b1;
                    case (r_act)
                        ACT_INSERT: begin
                            if (ge_cur) begin
                                r_p     <= i_prv_rdata;
                                r_state <= S_LINK;
                            end else begin
                                r_cur   <= i_nxt_rdata;
                                r_state <= S_WALK_RD;
                            end
                        end
                        ACT_COUNT: begin
                            if (ge_cur) begin
                                r_state <= S_DONE;
                            end else begin
                                if (eq_cur) begin
                                    r_occ <= r_occ + 1'b1;
                                    r_hit <= 1'b1;
                                end
                                r_cur   <= i_nxt_rdata;
                                r_state <= S_WALK_RD;
                            end
                        end
                        default: begin
                            if (eq_cur) begin
                                r_hit   <= 1'b1;
                                r_p     <= i_prv_rdata;
                                r_n     <= i_nxt_rdata;
                                r_state <= (r_act == ACT_REMOVE) ? S_RM_FIX : S_DONE;
                            end else if (ge_cur) begin
                                r_state <= S_DONE;
                            end else begin
                                r_cur   <= i_nxt_rdata;
                                r_state <= S_WALK_RD;
                            end
                        end
                    endcase
                end
                S_LINK: begin
                    if (!live(r_p)) begin
                        r_head <= r_new;
                    end
                    if (!live(r_cur)) begin
                        r_tail <= r_new;
                    end
                    r_count <= r_count + 1'b1;
                    r_hit   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_RM_FIX: begin
                    if (!live(r_p)) begin
                        r_head <= r_n;
                    end
                    if (!live(r_n)) begin
                        r_tail <= r_p;
                    end
                    r_free  <= r_cur;
                    r_count <= r_count - 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold here while the previous beat still waits.
                    if (rsp_load) begin
                        r_rsp.found       <= r_hit;
                        r_rsp.occurrences <= 8'(r_occ);
                        r_rsp.entries     <= 8'(r_count);
                        r_rsp.is_empty    <= r_count == '0;
                        r_rsp.rejected    <= r_rej;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

[sv/sorted_multiset_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_table_top
// Sorted bag of signed values kept as a doubly linked list in memories.
// ----------------------------------------------------------------------------
// After reset the block loads the free chain and then takes requests. Each
// request walks the list from the head, with a memory read and then a
// compare for each visited slot. One item is in flight at a time. The
// result beat waits in an output register, so the next request is taken
// while it is still unsent; the sequencer only stalls in its final step if
// the previous beat has not yet left by then.
`default_nettype none

module sorted_multiset_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smt_req_if.sink   req,
    smt_rsp_if.source rsp
);
    import smt_pkg::*;

    logic                init;
    logic [IdxWidth-1:0] val_raddr, val_waddr, nxt_raddr, prv_raddr;
    logic                val_we;
    t_value              val_wdata, val_rdata;
    t_link_wr            nxt_wr, prv_wr;
    t_slot               nxt_rdata, prv_rdata;

    smt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req         (req),
        .rsp         (rsp),
        .o_init      (init),
        .o_val_raddr (val_raddr),
        .o_val_we    (val_we),
        .o_val_waddr (val_waddr),
        .o_val_wdata (val_wdata),
        .i_val_rdata (val_rdata),
        .o_nxt_raddr (nxt_raddr),
        .o_nxt_wr    (nxt_wr),
        .i_nxt_rdata (nxt_rdata),
        .o_prv_raddr (prv_raddr),
        .o_prv_wr    (prv_wr),
        .i_prv_rdata (prv_rdata)
    );

    smt_value_ram u_val (
        .i_clk   (i_clk),
        .i_raddr (val_raddr),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .o_rdata (val_rdata)
    );

    smt_link_ram u_next (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (init),
        .i_raddr (nxt_raddr),
        .i_wr    (nxt_wr),
        .o_rdata (nxt_rdata)
    );

    smt_link_ram u_prev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (1'b0),
        .i_raddr (prv_raddr),
        .i_wr    (prv_wr),
        .o_rdata (prv_rdata)
    );
endmodule

`default_nettype wire

[sv/smt_checker.sv]
// ----------------------------------------------------------------------------
// smt_checker
// Port-level checks on the request and result channels of the multiset table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_multiset_table_top_defines.svh"

module smt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_found,
    input wire logic [7:0] i_occ,
    input wire logic [7:0] i_entries,
    input wire logic       i_empty,
    input wire logic       i_rej
);
    `SMT_ASSERT_SAME(a_empty_match, i_clk, i_rst_n, i_out_valid, i_empty == (i_entries == 8'd0), "empty flag disagrees with entries")
    `SMT_ASSERT_SAME(a_rej_not_found, i_clk, i_rst_n, i_out_valid && i_rej, !i_found && i_occ == 8'd0, "rejected beat reports a hit")
    `SMT_ASSERT_SAME(a_occ_found, i_clk, i_rst_n, i_out_valid && i_occ != 8'd0, i_found, "occurrences without found")
    `SMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_entries), "result beat dropped while stalled")
    `SMT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second beat taken while busy")
endmodule

bind sorted_multiset_table_top smt_checker u_smt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (req.valid),
    .i_in_ready  (req.ready),
    .i_out_valid (rsp.valid),
    .i_out_ready (rsp.ready),
    .i_found     (rsp.found),
    .i_occ       (rsp.occurrences),
    .i_entries   (rsp.entries),
    .i_empty     (rsp.is_empty),
    .i_rej       (rsp.rejected)
);

`default_nettype wire
